/* rtl/wiom_pkg.sv */
// Package: widths, minimum valid count and ring control struct for the window outlier mean unit.
`timescale 1ns / 1ps

package wiom_pkg;

    localparam int WIN       = 16;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = $clog2(WIN);
    localparam int CNT_W     = $clog2(WIN + 1);
    localparam int STEP_W    = IDX_W + 1;
    localparam int SUM_W     = VAL_W + IDX_W;
    localparam int FENCE_W   = VAL_W + 2;
    localparam int DCNT_W    = $clog2(SUM_W + 1);
    localparam int MIN_VALID = 4;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_ring_ctl;

endpackage

/* rtl/wiom_if.sv */
// Interfaces: sample input channel and result output channel.
`timescale 1ns / 1ps

interface wiom_in_if;
    import wiom_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample_value;
    logic             sample_valid;
    modport source(output valid, sample_value, sample_valid, input ready);
    modport sink(input valid, sample_value, sample_valid, output ready);
endinterface

interface wiom_out_if;
    import wiom_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] average;
    logic             average_valid;
    logic             outliers_discarded;
    modport source(output valid, average, average_valid, outliers_discarded, input ready);
    modport sink(input valid, average, average_valid, outliers_discarded, output ready);
endinterface

/* rtl/wiom_ring.sv */
// Sample window held as a ring of registers: shift in a new sample or rotate by one.
`timescale 1ns / 1ps

module wiom_ring (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wiom_pkg::t_ring_ctl       i_ctl,
    input  logic [wiom_pkg::VAL_W-1:0] i_value,
    input  logic                      i_ok,
    output logic [wiom_pkg::VAL_W-1:0] o_head_value,
    output logic                      o_head_ok,
    output logic [wiom_pkg::WIN-1:0]  o_ok_vec
);
    import wiom_pkg::*;

    logic [VAL_W-1:0] r_value [WIN];
    logic [WIN-1:0]   r_ok;

    // validity bits: cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_ctl.shift) begin
            r_ok <= {r_ok[WIN-2:0], i_ok};
        end else if (i_ctl.rotate) begin
            r_ok <= {r_ok[0], r_ok[WIN-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value[0] <= i_value;
            for (int k = 1; k < WIN; k++) begin
                r_value[k] <= r_value[k-1];
            end
        end else if (i_ctl.rotate) begin
            r_value[WIN-1] <= r_value[0];
            for (int k = 0; k < WIN - 1; k++) begin
                r_value[k] <= r_value[k+1];
            end
        end
    end

    assign o_head_value = r_value[0];
    assign o_head_ok    = r_ok[0];
    assign o_ok_vec     = r_ok;

endmodule

/* rtl/wiom_div.sv */
// Restoring divider: one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps

module wiom_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wiom_pkg::SUM_W-1:0] i_dividend,
    input  logic [wiom_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [wiom_pkg::SUM_W-1:0] o_quotient
);
    import wiom_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/window_iqr_outlier_mean_unit.sv */
// Top level: windowed luminosity mean with interquartile upper-fence outlier rejection.
//
//  channel    dir  port       payload
//  ---------  ---  ---------  -----------------------------------------------
//  sample     in   i_sample   sample_value[31:0], sample_valid
//  result     out  o_result   average[31:0], average_valid, outliers_discarded
//
// Each accepted sample enters a 16-entry register ring. With at least four valid
// entries the result reaches the output register after these steps: a count, 16
// rank passes that rotate the ring past one comparator, 4 quartile and fence steps,
// a sum sweep over the 16 entries, a divider start, a divide of 36 quotient bits
// plus done, and a load; the next sample is taken only once the sequencer is idle.
// With fewer than four valid entries the result is loaded straight after the count.
// i_sample.ready is high only while idle; a finished result waits in the output
// register, and the next sample can be taken while it waits. A result that finds the
// output register still full holds the sequencer until the register drains. Reset
// clears the ring's validity bits, the sequencer and the output valid.
`timescale 1ns / 1ps

module window_iqr_outlier_mean_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wiom_in_if.sink     i_sample,
    wiom_out_if.source  o_result
);
    import wiom_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_COUNT = 11'b00000000010,
        S_RANK  = 11'b00000000100,
        S_MED   = 11'b00000001000,
        S_IQR   = 11'b00000010000,
        S_FEN1  = 11'b00000100000,
        S_FEN2  = 11'b00001000000,
        S_SUM   = 11'b00010000000,
        S_DIVGO = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // rank sweep bookkeeping
    logic [IDX_W-1:0]  r_pass, n_pass;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_rank, n_rank;
    logic [VAL_W-1:0]  r_cand, n_cand;
    logic              r_cand_ok, n_cand_ok;

    // target ranks of the four order statistics
    logic [IDX_W-1:0]  r_tq1a, n_tq1a, r_tq1b, n_tq1b, r_tq3a, n_tq3a, r_tq3b, n_tq3b;
    logic [VAL_W-1:0]  r_q1a, n_q1a, r_q1b, n_q1b, r_q3a, n_q3a, r_q3b, n_q3b;

    logic [VAL_W-1:0]   r_q1, n_q1, r_q3, n_q3, r_iqr, n_iqr;
    logic [FENCE_W-1:0] r_fence, n_fence;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_kept, n_kept;

    // finished result, and the output register
    logic [VAL_W-1:0] r_res_avg, n_res_avg;
    logic             r_res_ok, n_res_ok;
    logic             r_res_disc, n_res_disc;
    logic [VAL_W-1:0] r_out_avg, n_out_avg;
    logic             r_out_ok, n_out_ok;
    logic             r_out_disc, n_out_disc;
    logic             r_out_valid, n_out_valid;

    t_ring_ctl        ring_ctl;
    logic [VAL_W-1:0] head_value;
    logic             head_ok;
    logic [WIN-1:0]   ok_vec;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] cnt_now;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] offs;
    logic [CNT_W-1:0] mid_a;
    logic [CNT_W-1:0] mid_b;
    logic             head_less;

    wiom_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ring_ctl),
        .i_value     (i_sample.sample_value),
        .i_ok        (i_sample.sample_valid),
        .o_head_value(head_value),
        .o_head_ok   (head_ok),
        .o_ok_vec    (ok_vec)
    );

    wiom_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_kept),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign out_xfer = r_out_valid && o_result.ready;

    assign o_result.valid              = r_out_valid;
    assign o_result.average            = r_out_avg;
    assign o_result.average_valid      = r_out_ok;
    assign o_result.outliers_discarded = r_out_disc;

    assign ring_ctl.shift  = in_xfer;
    assign ring_ctl.rotate = (r_state == S_RANK) || (r_state == S_SUM);
    assign div_start       = (r_state == S_DIVGO);

    // quartile ranks: each median is the floored mean of two ranks (equal when the half is odd)
    assign cnt_now = CNT_W'($countones(ok_vec));
    assign half    = cnt_now >> 1;
    assign offs    = half + CNT_W'(cnt_now[0]);
    assign mid_a   = (half - 1'b1) >> 1;
    assign mid_b   = half >> 1;

    // candidate outranks the head entry; equal values break ties by ring position
    assign head_less = head_ok && ((head_value < r_cand) ||
                       ((head_value == r_cand) &&
                        ((STEP_W'(r_pass) + r_step) >= STEP_W'(WIN))));

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_rank      = r_rank;
        n_cand      = r_cand;
        n_cand_ok   = r_cand_ok;
        n_tq1a      = r_tq1a;
        n_tq1b      = r_tq1b;
        n_tq3a      = r_tq3a;
        n_tq3b      = r_tq3b;
        n_q1a       = r_q1a;
        n_q1b       = r_q1b;
        n_q3a       = r_q3a;
        n_q3b       = r_q3b;
        n_q1        = r_q1;
        n_q3        = r_q3;
        n_iqr       = r_iqr;
        n_fence     = r_fence;
        n_sum       = r_sum;
        n_kept      = r_kept;
        n_res_avg   = r_res_avg;
        n_res_ok    = r_res_ok;
        n_res_disc  = r_res_disc;
        n_out_avg   = r_out_avg;
        n_out_ok    = r_out_ok;
        n_out_disc  = r_out_disc;
        n_out_valid = r_out_valid && !out_xfer;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_cnt  = cnt_now;
                n_tq1a = IDX_W'(mid_a);
                n_tq1b = IDX_W'(mid_b);
                n_tq3a = IDX_W'(offs + mid_a);
                n_tq3b = IDX_W'(offs + mid_b);
                n_pass = '0;
                n_step = '0;
                if (cnt_now < CNT_W'(MIN_VALID)) begin
                    // too few valid entries: report all zero
                    n_res_avg  = '0;
                    n_res_ok   = 1'b0;
                    n_res_disc = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_RANK;
                end
            end
            S_RANK: begin
                if (r_step == '0) begin
                    n_cand    = head_value;
                    n_cand_ok = head_ok;
                    n_rank    = '0;
                    n_step    = r_step + 1'b1;
                end else if (r_step != STEP_W'(WIN)) begin
                    if (head_less) begin
                        n_rank = r_rank + 1'b1;
                    end
                    n_step = r_step + 1'b1;
                end else begin
                    // rank final: keep the value if it is a wanted order statistic
                    if (r_cand_ok) begin
                        if (r_rank == r_tq1a) n_q1a = r_cand;
                        if (r_rank == r_tq1b) n_q1b = r_cand;
                        if (r_rank == r_tq3a) n_q3a = r_cand;
                        if (r_rank == r_tq3b) n_q3b = r_cand;
                    end
                    n_step = '0;
                    n_pass = r_pass + 1'b1;
                    if (r_pass == IDX_W'(WIN - 1)) begin
                        n_state = S_MED;
                    end
                end
            end
            S_MED: begin
                n_q1    = VAL_W'(({1'b0, r_q1a} + {1'b0, r_q1b}) >> 1);
                n_q3    = VAL_W'(({1'b0, r_q3a} + {1'b0, r_q3b}) >> 1);
                n_state = S_IQR;
            end
            S_IQR: begin
                n_iqr   = (r_q3 >= r_q1) ? (r_q3 - r_q1) : '0;
                n_state = S_FEN1;
            end
            S_FEN1: begin
                n_fence = FENCE_W'(r_q3) + FENCE_W'(r_iqr);
                n_state = S_FEN2;
            end
            S_FEN2: begin
                n_fence = r_fence + FENCE_W'(r_iqr >> 1);
                n_sum   = '0;
                n_kept  = '0;
                n_step  = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // keep entries at or below the fence
                if (head_ok && (FENCE_W'(head_value) <= r_fence)) begin
                    n_sum  = r_sum + SUM_W'(head_value);
                    n_kept = r_kept + 1'b1;
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(WIN - 1)) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_res_avg  = div_quo[VAL_W-1:0];
                    n_res_ok   = 1'b1;
                    n_res_disc = (r_kept != r_cnt);
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_out_avg   = r_res_avg;
                    n_out_ok    = r_res_ok;
                    n_out_disc  = r_res_disc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_rank     <= n_rank;
        r_cand     <= n_cand;
        r_cand_ok  <= n_cand_ok;
        r_tq1a     <= n_tq1a;
        r_tq1b     <= n_tq1b;
        r_tq3a     <= n_tq3a;
        r_tq3b     <= n_tq3b;
        r_q1a      <= n_q1a;
        r_q1b      <= n_q1b;
        r_q3a      <= n_q3a;
        r_q3b      <= n_q3b;
        r_q1       <= n_q1;
        r_q3       <= n_q3;
        r_iqr      <= n_iqr;
        r_fence    <= n_fence;
        r_sum      <= n_sum;
        r_kept     <= n_kept;
        r_res_avg  <= n_res_avg;
        r_res_ok   <= n_res_ok;
        r_res_disc <= n_res_disc;
        r_out_avg  <= n_out_avg;
        r_out_ok   <= n_out_ok;
        r_out_disc <= n_out_disc;
    end

endmodule

/* dv/wiom_mean_checker.sv */
// Checker: window mean predictor and result scoreboard for the outlier mean unit.
`timescale 1ns / 1ps

module wiom_mean_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    wiom_in_if   i_sample,
    wiom_out_if  i_result,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_results,
    output int   o_valid_means,
    output int   o_discards
);
    import wiom_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [VAL_W-1:0] average;
        logic             average_valid;
        logic             outliers_discarded;
    } t_mean_result;

    // Shadow of the sample ring, written in transfer order.
    logic [VAL_W-1:0] lux_win [WIN];
    logic             lux_ok  [WIN];
    logic [IDX_W-1:0] wr_pos;
    logic [VAL_W-1:0] sorted_lux [WIN];

    t_mean_result expected_means [$];

    // Median of len sorted entries from base; an even length floors the halved sum.
    function automatic logic [VAL_W-1:0] half_median(input int base, input int len);
        logic [VAL_W:0] pair;
        if (len % 2 == 0) begin
            pair = {1'b0, sorted_lux[base + len / 2 - 1]} + {1'b0, sorted_lux[base + len / 2]};
            return pair[VAL_W:1];
        end
        return sorted_lux[base + len / 2];
    endfunction

    // Mean of the valid ring entries at or below the upper fence.
    function automatic t_mean_result window_mean();
        int               n;
        int               half;
        int               i;
        int               j;
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] q1;
        logic [VAL_W-1:0] q3;
        logic [VAL_W-1:0] iqr;
        logic [63:0]      fence;
        logic [63:0]      total;
        logic [63:0]      kept;
        t_mean_result     res;
        res = '0;
        n = 0;
        for (i = 0; i < WIN; i++) begin
            if (lux_ok[i]) begin
                sorted_lux[n] = lux_win[i];
                n++;
            end
        end
        if (n < MIN_VALID) return res;
        for (i = 1; i < n; i++) begin
            key = sorted_lux[i];
            j = i;
            while (j > 0 && sorted_lux[j - 1] > key) begin
                sorted_lux[j] = sorted_lux[j - 1];
                j--;
            end
            sorted_lux[j] = key;
        end
        half  = n / 2;
        q1    = half_median(0, half);
        q3    = half_median(half + n % 2, half);
        iqr   = (q3 >= q1) ? q3 - q1 : '0;
        fence = 64'(q3) + 64'(iqr) + 64'(iqr >> 1);
        total = '0;
        kept  = '0;
        for (i = 0; i < n; i++) begin
            if (64'(sorted_lux[i]) <= fence) begin
                total += 64'(sorted_lux[i]);
                kept++;
            end
        end
        res.average            = (kept != 0) ? VAL_W'(total / kept) : '0;
        res.average_valid      = 1'b1;
        res.outliers_discarded = (kept < 64'(n));
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_mean_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                lux_win[k] = '0;
                lux_ok[k]  = 1'b0;
            end
            wr_pos = '0;
            expected_means.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
            o_results     = 0;
            o_valid_means = 0;
            o_discards    = 0;
        end else begin
            // Retire the result first: it always belongs to an earlier sample.
            if (i_result.valid && i_result.ready) begin
                if (expected_means.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_MAX)
                        $display("[%0t] unexpected result: average=%h valid=%b discarded=%b",
                                 $realtime, i_result.average, i_result.average_valid,
                                 i_result.outliers_discarded);
                end else begin
                    want = expected_means.pop_front();
                    o_results++;
                    if (want.average_valid) o_valid_means++;
                    if (want.outliers_discarded) o_discards++;
                    if (i_result.average !== want.average
                        || i_result.average_valid !== want.average_valid
                        || i_result.outliers_discarded !== want.outliers_discarded) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_MAX)
                            $display({"[%0t] result %0d: average exp %h got %h, ",
                                      "valid exp %b got %b, discarded exp %b got %b"},
                                     $realtime, o_results, want.average, i_result.average,
                                     want.average_valid, i_result.average_valid,
                                     want.outliers_discarded, i_result.outliers_discarded);
                    end
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                lux_win[wr_pos] = i_sample.sample_value;
                lux_ok[wr_pos]  = i_sample.sample_valid;
                wr_pos          = wr_pos + 1'b1;
                expected_means.push_back(window_mean());
            end
            o_outstanding = expected_means.size();
        end
    end

endmodule

/* dv/tb_window_iqr_outlier_mean_unit.sv */
// Testbench top: stimulus, handshake pacing and verdict for the outlier mean unit.
`timescale 1ns / 1ps

module tb_window_iqr_outlier_mean_unit;
    import wiom_pkg::*;

    // Longest legal quiet stretch is a sender gap plus a full sort pass plus a
    // receiver stall burst; allow several times that.
    localparam int STALL_LIMIT   = 8000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASES        = 4;
    localparam int ITEMS_PER_PH  = 100;
    localparam int LONG_GAP_MAX  = 360;

    // Sender idle and receiver stall percentages per phase.
    localparam int SENDER_IDLE [PHASES] = '{0, 63, 0, 34};
    localparam int SINK_STALL  [PHASES] = '{0, 0, 63, 34};

    // Directed samples as {sample_valid, sample_value}.
    localparam int DIRECTED_N = 24;
    localparam logic [VAL_W:0] DIRECTED [DIRECTED_N] = '{
        {1'b0, 32'hFFFF_FFFF},  // invalid slot with all value bits set
        {1'b1, 32'h0000_0000},
        {1'b1, 32'h0000_0000},
        {1'b1, 32'h0000_0000},  // three valid entries: result still invalid
        {1'b1, 32'h0000_0000},  // fourth valid entry: first real mean
        {1'b1, 32'h0000_0004},
        {1'b1, 32'h0000_0004},
        {1'b1, 32'h0000_0004},
        {1'b1, 32'h0000_000A},  // lands exactly on the fence, must be kept
        {1'b1, 32'h0000_0004},
        {1'b1, 32'h0000_0004},
        {1'b1, 32'h0000_000B},  // one above the fence, dropped
        {1'b1, 32'hFFFF_FFFF},  // extreme outlier
        {1'b0, 32'h5A5A_5A5A},
        {1'b1, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF},  // ring has already wrapped; sums and fence exceed 32 bits
        {1'b1, 32'hFFFF_FFFE},
        {1'b1, 32'h8000_0000},
        {1'b1, 32'h0000_0001},
        {1'b0, 32'h0000_0000}
    };

    typedef enum logic [2:0] {
        RUN_DIM,
        RUN_MID,
        RUN_BRIGHT,
        RUN_NOISE,
        RUN_SPARSE
    } t_lux_run;

    logic i_clk;
    logic i_rst_n;

    wiom_in_if  sample_if ();
    wiom_out_if result_if ();

    int mismatches;
    int outstanding;
    int results_checked;
    int valid_means;
    int discard_events;

    int sender_idle_pct;
    int sink_stall_pct;
    int stall_burst;
    int quiet_cycles;
    int samples_sent;
    int invalid_sent;

    t_lux_run         run_kind;
    int               run_left;
    logic [VAL_W-1:0] run_base;
    int               run_spread;

    window_iqr_outlier_mean_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if)
    );

    wiom_mean_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (sample_if),
        .i_result      (result_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results_checked),
        .o_valid_means (valid_means),
        .o_discards    (discard_events)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver pacing: per-cycle stalls, plus rare long bursts so that a finished
    // result sits in the output register while the next sample is being sorted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready = 1'b0;
            stall_burst     = 0;
        end else if (stall_burst > 0) begin
            result_if.ready = 1'b0;
            stall_burst--;
        end else if (sink_stall_pct > 0 && $urandom_range(0, 999) < 2) begin
            result_if.ready = 1'b0;
            stall_burst     = $urandom_range(1, LONG_GAP_MAX);
        end else begin
            result_if.ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: abort when neither channel moves a transfer for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_if.valid && sample_if.ready)
            || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                         quiet_cycles, outstanding);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one sample and hold it until the block takes it. Valid stays high
    // after the transfer so back-to-back samples never toggle it within a step.
    task automatic send_sample(input logic [VAL_W-1:0] lux, input logic ok);
        int gap;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            // Mostly short gaps; a quarter are long enough to land deep in the sort.
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LONG_GAP_MAX)
                                              : $urandom_range(1, 4);
            sample_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_if.valid        = 1'b1;
        sample_if.sample_value = lux;
        sample_if.sample_valid = ok;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
        if (!ok) invalid_sent++;
    endtask

    // Build light-level runs: a steady level with jitter, ties, upward spikes,
    // dropouts and the odd full-range value. Sparse runs pull the valid count
    // below four and back again.
    task automatic make_sample(output logic [VAL_W-1:0] lux, output logic ok);
        logic [63:0] wide;
        int          pick;
        if (run_left == 0) begin
            run_kind = t_lux_run'($urandom_range(0, 4));
            run_left = $urandom_range(6, 40);
            case (run_kind)
                RUN_DIM, RUN_SPARSE: begin
                    run_base   = $urandom_range(0, 4000);
                    run_spread = $urandom_range(0, 600);
                end
                RUN_MID: begin
                    run_base   = $urandom >> 4;
                    run_spread = $urandom_range(0, 1 << 20);
                end
                RUN_BRIGHT: begin
                    run_base   = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
                    run_spread = $urandom_range(0, 1 << 20);
                end
                default: begin
                    run_base   = '0;
                    run_spread = 0;
                end
            endcase
        end
        run_left--;
        pick = $urandom_range(0, 99);
        ok   = 1'b1;
        if (pick < ((run_kind == RUN_SPARSE) ? 80 : 8)) begin
            ok  = 1'b0;
            lux = $urandom;
        end else if (run_kind == RUN_NOISE || pick >= 95) begin
            lux = $urandom;
        end else if (pick >= 85) begin
            wide = 64'(run_base) + 64'(run_spread) * 64'($urandom_range(3, 12))
                 + 64'($urandom_range(1, 50));
            lux  = (wide > 64'hFFFF_FFFF) ? '1 : wide[VAL_W-1:0];
        end else if (pick < 20) begin
            lux = run_base;
        end else begin
            wide = 64'(run_base) + 64'($urandom_range(0, run_spread));
            lux  = (wide > 64'hFFFF_FFFF) ? '1 : wide[VAL_W-1:0];
        end
    endtask

    initial begin : stimulus
        logic [VAL_W-1:0] lux;
        logic             ok;
        i_rst_n                = 1'b0;
        sample_if.valid        = 1'b0;
        sample_if.sample_value = '0;
        sample_if.sample_valid = 1'b0;
        sender_idle_pct        = 0;
        sink_stall_pct         = 0;
        samples_sent           = 0;
        invalid_sent           = 0;
        run_left               = 0;
        run_kind               = RUN_DIM;
        run_base               = '0;
        run_spread             = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corner cases run without any idling.
        for (int d = 0; d < DIRECTED_N; d++)
            send_sample(DIRECTED[d][VAL_W-1:0], DIRECTED[d][VAL_W]);

        // Random runs under each pacing phase in turn.
        for (int ph = 0; ph < PHASES; ph++) begin
            sender_idle_pct = SENDER_IDLE[ph];
            sink_stall_pct  = SINK_STALL[ph];
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                make_sample(lux, ok);
                send_sample(lux, ok);
            end
        end

        // Drop valid, then drain every pending result and watch for strays.
        sample_if.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d samples (%0d invalid) over four pacing phases.",
                 samples_sent, invalid_sent);
        $display("Checked %0d results: %0d with a valid mean, %0d with outliers rejected.",
                 results_checked, valid_means, discard_events);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/wiom_pkg.sv
rtl/wiom_if.sv
rtl/wiom_ring.sv
rtl/wiom_div.sv
rtl/window_iqr_outlier_mean_unit.sv
dv/wiom_mean_checker.sv
dv/tb_window_iqr_outlier_mean_unit.sv
